@@ src/utu_pkg.sv @@
// ============================================================================
// utu_pkg: shared types and constants for the UTF-8 to UCS-2 decoder
// Holds the queue word passed from the front end to the output stage, the
// front-end status group and the code-unit constants used in decoding.
// ============================================================================
package utu_pkg;

    // Unit given for any malformed or unrepresentable sequence ('?')
    localparam logic [15:0] ERR_UNIT = 16'h003F;
    // Terminator unit
    localparam logic [15:0] TERM_UNIT = 16'h0000;
    // Smallest values that are not overlong for 2- and 3-byte forms
    localparam logic [15:0] MIN_TWO_BYTE = 16'h0080;
    localparam logic [15:0] MIN_THREE_BYTE = 16'h0800;
    // Capacity after reset
    localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

    // One queue word: an optional code unit, then an optional terminator
    typedef struct packed {
        logic        has_unit;
        logic [15:0] unit;
        logic        has_term;
    } queue_entry_t;

    // Front-end string state, exported for checking
    typedef struct packed {
        logic        output_full;
        logic [2:0]  bytes_pending;
        logic [15:0] units_written;
        logic [15:0] room;
    } front_status_t;

endpackage

@@ src/utu_ifs.sv @@
// ============================================================================
// utu_ifs: valid/ready channels of the UTF-8 to UCS-2 decoder
// Byte input channel, code-unit output channel and capacity write channel.
// ============================================================================
interface utu_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface utu_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        is_terminator;

    modport source (output valid, output code_unit, output is_terminator, input ready);
    modport sink (input valid, input code_unit, input is_terminator, output ready);
endinterface

interface utu_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] capacity;

    modport source (output valid, output capacity, input ready);
    modport sink (input valid, input capacity, output ready);
endinterface

@@ src/utu_front.sv @@
// ============================================================================
// utu_front: byte intake and sequence decoding
// Accepts one UTF-8 byte per cycle while the queue has room, tracks the open
// sequence, applies the capacity limit, pushes one queue word per byte with a result.
// ============================================================================
module utu_front (
    input  logic                 clk,
    input  logic                 rst_n,
    utu_byte_if.sink             utf8,
    utu_cfg_if.sink              cfg,
    input  logic                 queue_full,
    output logic                 push_valid,
    output utu_pkg::queue_entry_t push_entry,
    output utu_pkg::front_status_t status
);
    import utu_pkg::*;

    logic [15:0] capacity_reg;
    logic [2:0]  pending_reg, pending_next;
    logic [2:0]  seq_len_reg, seq_len_next;
    logic [15:0] acc_reg, acc_next;
    logic [15:0] units_reg, units_next;
    logic        full_reg, full_next;

    logic [15:0] room;
    logic        accept;
    logic [7:0]  b;
    logic        last;
    logic        unit_req;
    logic [15:0] unit_val;
    logic [15:0] acc_merged;
    logic        put_ok;

    // Capacity register, writable at any time the channel offers a word
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else if (cfg.valid)
        begin
            capacity_reg <= cfg.capacity;
        end
    end

    // Units that fit before the terminator; zero capacity acts as one
    assign room = (capacity_reg == 16'd0) ? 16'd0 : capacity_reg - 16'd1;

    assign utf8.ready = !queue_full;
    assign accept     = utf8.valid && utf8.ready;
    assign b          = utf8.data_byte;
    assign last       = utf8.final_byte;

    // Decode one byte against the open sequence
    always_comb
    begin
        pending_next = pending_reg;
        seq_len_next = seq_len_reg;
        acc_next     = acc_reg;
        units_next   = units_reg;
        full_next    = full_reg;
        unit_req     = 1'b0;
        unit_val     = ERR_UNIT;
        acc_merged   = acc_reg;
        if (!full_reg)
        begin
            if (pending_reg == 3'd0)
            begin
                // lead byte
                if (b[7] == 1'b0)
                begin
                    unit_req = 1'b1;
                    unit_val = {8'h00, b};
                end
                else if (b[7:5] == 3'b110)
                begin
                    seq_len_next = 3'd2;
                    pending_next = 3'd1;
                    acc_next     = {5'b0, b[4:0], 6'b0};
                end
                else if (b[7:4] == 4'b1110)
                begin
                    seq_len_next = 3'd3;
                    pending_next = 3'd2;
                    acc_next     = {b[3:0], 12'b0};
                end
                else if (b[7:3] == 5'b11110)
                begin
                    seq_len_next = 3'd4;
                    pending_next = 3'd3;
                    acc_next     = 16'd0;
                end
                else if (b[7:2] == 6'b111110)
                begin
                    seq_len_next = 3'd5;
                    pending_next = 3'd4;
                    acc_next     = 16'd0;
                end
                else if (b[7:1] == 7'b1111110)
                begin
                    seq_len_next = 3'd6;
                    pending_next = 3'd5;
                    acc_next     = 16'd0;
                end
                else
                begin
                    unit_req = 1'b1;
                    unit_val = ERR_UNIT;
                end
            end
            else
            begin
                // continuation byte, taken unchecked
                pending_next = pending_reg - 3'd1;
                if (seq_len_reg <= 3'd3)
                begin
                    if (pending_next == 3'd1)
                    begin
                        acc_merged = acc_reg | {4'b0, b[5:0], 6'b0};
                    end
                    else
                    begin
                        acc_merged = acc_reg | {10'b0, b[5:0]};
                    end
                end
                acc_next = acc_merged;
                if (pending_next == 3'd0)
                begin
                    unit_req = 1'b1;
                    if (seq_len_reg == 3'd2)
                    begin
                        unit_val = (acc_merged < MIN_TWO_BYTE) ? ERR_UNIT : acc_merged;
                    end
                    else if (seq_len_reg == 3'd3)
                    begin
                        unit_val = (acc_merged < MIN_THREE_BYTE) ? ERR_UNIT : acc_merged;
                    end
                    else
                    begin
                        unit_val = ERR_UNIT;
                    end
                    seq_len_next = 3'd0;
                    acc_next     = 16'd0;
                end
            end
            // string ends inside a sequence
            if (last && (pending_next != 3'd0))
            begin
                unit_req = 1'b1;
                unit_val = ERR_UNIT;
            end
        end

        // capacity check
        put_ok = unit_req && (units_reg < room);
        if (unit_req && !put_ok)
        begin
            full_next = 1'b1;
        end
        if (put_ok)
        begin
            units_next = units_reg + 16'd1;
        end

        // end of string clears everything
        if (last)
        begin
            pending_next = 3'd0;
            seq_len_next = 3'd0;
            acc_next     = 16'd0;
            units_next   = 16'd0;
            full_next    = 1'b0;
        end
    end

    // String state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 3'd0;
            seq_len_reg <= 3'd0;
            acc_reg     <= 16'd0;
            units_reg   <= 16'd0;
            full_reg    <= 1'b0;
        end
        else if (accept)
        begin
            pending_reg <= pending_next;
            seq_len_reg <= seq_len_next;
            acc_reg     <= acc_next;
            units_reg   <= units_next;
            full_reg    <= full_next;
        end
    end

    // Queue word for this byte
    assign push_valid          = accept && (put_ok || last);
    assign push_entry.has_unit = put_ok;
    assign push_entry.unit     = unit_val;
    assign push_entry.has_term = last;

    assign status.output_full   = full_reg;
    assign status.bytes_pending = pending_reg;
    assign status.units_written = units_reg;
    assign status.room          = room;

endmodule

@@ src/utu_queue.sv @@
// ============================================================================
// utu_queue: word queue between the decoder and the output stage
// Small flop FIFO; one push and one pop per cycle, a push only while not full and a pop only while not empty.
// ============================================================================
module utu_queue #(
    parameter int DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  utu_pkg::queue_entry_t push_entry,
    input  logic                  pop,
    output utu_pkg::queue_entry_t head,
    output logic                  empty,
    output logic                  full
);
    import utu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    queue_entry_t entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign empty   = (count_reg == CNT_W'(0));
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entries_reg[rd_ptr_reg];

    // Pointer and count update with wrap at the last slot
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ src/utu_back.sv @@
// ============================================================================
// utu_back: output stage
// Unpacks queue words into code units and terminators, one per cycle unless
// the receiver stalls, into a registered output word.
// ============================================================================
module utu_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  utu_pkg::queue_entry_t head,
    input  logic                  queue_empty,
    output logic                  pop,
    utu_unit_if.source            ucs2
);
    import utu_pkg::*;

    logic        out_valid_reg, out_valid_next;
    logic        term_pend_reg, term_pend_next;
    logic [15:0] unit_reg, unit_next;
    logic        is_term_reg, is_term_next;
    logic        load;

    // Output register can take a new word when empty or being drained
    assign load = !out_valid_reg || ucs2.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        term_pend_next = term_pend_reg;
        unit_next      = unit_reg;
        is_term_next   = is_term_reg;
        pop            = 1'b0;
        if (load)
        begin
            if (term_pend_reg)
            begin
                // terminator left over from a two-result word
                out_valid_next = 1'b1;
                unit_next      = TERM_UNIT;
                is_term_next   = 1'b1;
                term_pend_next = 1'b0;
            end
            else if (!queue_empty)
            begin
                pop            = 1'b1;
                out_valid_next = 1'b1;
                if (head.has_unit)
                begin
                    unit_next      = head.unit;
                    is_term_next   = 1'b0;
                    term_pend_next = head.has_term;
                end
                else
                begin
                    unit_next    = TERM_UNIT;
                    is_term_next = 1'b1;
                end
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            term_pend_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            term_pend_reg <= term_pend_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        unit_reg    <= unit_next;
        is_term_reg <= is_term_next;
    end

    assign ucs2.valid         = out_valid_reg;
    assign ucs2.code_unit     = unit_reg;
    assign ucs2.is_terminator = is_term_reg;

endmodule

@@ src/utf8_to_ucs2_decoder_top.sv @@
// ============================================================================
// utf8_to_ucs2_decoder_top: UTF-8 to UCS-2 string decoder
// Decodes a UTF-8 byte stream into 16-bit code units with a closing zero.
// ============================================================================
// Usage:
//   utf8 : input words, one byte (data_byte) plus final_byte on the last
//          byte of a string. Valid/ready; a word moves when both are high.
//   ucs2 : output words, code_unit plus is_terminator on the closing zero.
//   cfg  : capacity writes (buffer size in units, terminator included);
//          always ready, write only between strings.
// Throughput: one byte per cycle while the queue has room. A final byte that
//   also completes a unit yields two output words; the queue between
//   decoder and output stage absorbs these.
// Path: an accepted byte is written into the queue as a word, which is then
//   loaded into the output register once that register can take a new word.
// Stall: when ucs2.ready is low the output word holds, the queue fills,
//   and utf8.ready drops once QUEUE_DEPTH words are waiting.
// Reset: capacity returns to 65535, the string state and queue clear, and
//   the output channel goes idle.
// ============================================================================
module utf8_to_ucs2_decoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    utu_byte_if.sink   utf8,
    utu_unit_if.source ucs2,
    utu_cfg_if.sink    cfg
);
    import utu_pkg::*;

    queue_entry_t  push_entry;
    queue_entry_t  head;
    front_status_t status;
    logic          push_valid;
    logic          queue_full;
    logic          queue_empty;
    logic          pop;

    // Byte intake and decoding
    utu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .utf8       (utf8),
        .cfg        (cfg),
        .queue_full (queue_full),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .status     (status)
    );

    // Decoupling queue
    utu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push_valid),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (queue_empty),
        .full       (queue_full)
    );

    // Output stage
    utu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .queue_empty (queue_empty),
        .pop         (pop),
        .ucs2        (ucs2)
    );

    // A decoded word is never pushed into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> !queue_full)
        else $error("push into full queue");

    // The full flag is set only once the unit count has reached the room
    assert property (@(posedge clk) disable iff (!rst_n)
        status.output_full |-> (status.units_written >= status.room))
        else $error("output full before capacity reached");

    // A final byte leaves a clean string state behind
    assert property (@(posedge clk) disable iff (!rst_n)
        (utf8.valid && utf8.ready && utf8.final_byte) |=>
            (status.bytes_pending == 3'd0 && status.units_written == 16'd0
             && !status.output_full))
        else $error("string state not cleared after final byte");

endmodule

@@ tb/sv/utu_decode_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// utu_decode_checker: scoreboard for the UTF-8 to UCS-2 decoder
// Watches the byte, code-unit and capacity channels, keeps its own copy of
// the string state and capacity, predicts the words each accepted byte
// causes, and compares every accepted output word against the oldest one.
// ============================================================================
module utu_decode_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    input  logic        byte_ready,
    input  logic [7:0]  data_byte,
    input  logic        final_byte,
    input  logic        unit_valid,
    input  logic        unit_ready,
    input  logic [15:0] code_unit,
    input  logic        is_terminator,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_capacity,
    output int          fail_count,
    output int          units_pending
);
    import utu_pkg::*;

    localparam int MAX_REPORTS = 50;

    typedef struct packed {
        logic [15:0] code_val;
        logic        term;
    } ucs2_word_t;

    // expected output words, oldest first
    ucs2_word_t  expected_words[$];

    // predicted decoder state
    logic [15:0] capacity_cfg;
    logic [2:0]  cont_left;
    logic [2:0]  seq_len;
    logic [15:0] acc_bits;
    logic [15:0] units_out;
    logic        buf_full;

    // one line per mismatch; printing stops after a while, counting does not
    task automatic report_mismatch(input string what);
        if (fail_count < MAX_REPORTS)
            $display("%0t ns: decoder mismatch: %s", $time, what);
        fail_count++;
    endtask

    task automatic clear_string();
        cont_left = 3'd0;
        seq_len   = 3'd0;
        acc_bits  = 16'd0;
        units_out = 16'd0;
        buf_full  = 1'b0;
    endtask

    // a unit that finds no room is dropped and the buffer counts as full
    task automatic store_unit(input logic [15:0] code_val);
        logic [15:0] room;
        room = (capacity_cfg == 16'd0) ? 16'd0 : capacity_cfg - 16'd1;
        if (buf_full || units_out >= room)
            buf_full = 1'b1;
        else
        begin
            expected_words.push_back('{code_val: code_val, term: 1'b0});
            units_out = units_out + 16'd1;
        end
    endtask

    // predict the words caused by one accepted byte
    task automatic decode_byte(input logic [7:0] b, input logic last);
        logic [15:0] code_val;
        if (!buf_full)
        begin
            if (cont_left == 3'd0)
            begin
                // lead byte picks the sequence length
                if (b[7] == 1'b0)
                    store_unit({8'h00, b});
                else if (b[7:5] == 3'b110)
                begin
                    seq_len   = 3'd2;
                    cont_left = 3'd1;
                    acc_bits  = {5'b0, b[4:0], 6'b0};
                end
                else if (b[7:4] == 4'b1110)
                begin
                    seq_len   = 3'd3;
                    cont_left = 3'd2;
                    acc_bits  = {b[3:0], 12'b0};
                end
                else if (b[7:3] == 5'b11110)
                begin
                    seq_len   = 3'd4;
                    cont_left = 3'd3;
                    acc_bits  = 16'd0;
                end
                else if (b[7:2] == 6'b111110)
                begin
                    seq_len   = 3'd5;
                    cont_left = 3'd4;
                    acc_bits  = 16'd0;
                end
                else if (b[7:1] == 7'b1111110)
                begin
                    seq_len   = 3'd6;
                    cont_left = 3'd5;
                    acc_bits  = 16'd0;
                end
                else
                    store_unit(ERR_UNIT);
            end
            else
            begin
                // continuation: low six bits, value never checked
                cont_left = cont_left - 3'd1;
                if (seq_len <= 3'd3)
                    acc_bits = acc_bits | ((cont_left == 3'd1) ? {4'b0, b[5:0], 6'b0}
                                                               : {10'b0, b[5:0]});
                if (cont_left == 3'd0)
                begin
                    code_val = acc_bits;
                    if (seq_len == 3'd2 && acc_bits < MIN_TWO_BYTE)
                        code_val = ERR_UNIT;
                    else if (seq_len == 3'd3 && acc_bits < MIN_THREE_BYTE)
                        code_val = ERR_UNIT;
                    else if (seq_len > 3'd3)
                        code_val = ERR_UNIT;
                    seq_len  = 3'd0;
                    acc_bits = 16'd0;
                    store_unit(code_val);
                end
            end
            // string ends inside a sequence
            if (last && cont_left != 3'd0)
                store_unit(ERR_UNIT);
        end
        if (last)
        begin
            expected_words.push_back('{code_val: TERM_UNIT, term: 1'b1});
            clear_string();
        end
    endtask

    task automatic check_word(input logic [15:0] got_code, input logic got_term);
        ucs2_word_t want;
        if (expected_words.size() == 0)
            report_mismatch($sformatf("unexpected word code_unit=%h is_terminator=%b",
                                      got_code, got_term));
        else
        begin
            want = expected_words.pop_front();
            if (got_code !== want.code_val)
                report_mismatch($sformatf("code_unit %h, expected %h", got_code,
                                          want.code_val));
            if (got_term !== want.term)
                report_mismatch($sformatf("is_terminator %b, expected %b (code_unit %h)",
                                          got_term, want.term, want.code_val));
        end
    endtask

    // sample all three channels at the clock edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_cfg = CAPACITY_RESET;
            clear_string();
            expected_words.delete();
        end
        else
        begin
            if (unit_valid && unit_ready)
                check_word(code_unit, is_terminator);
            if (cfg_valid && cfg_ready)
                capacity_cfg = cfg_capacity;
            if (byte_valid && byte_ready)
                decode_byte(data_byte, final_byte);
        end
        units_pending = expected_words.size();
    end

endmodule

@@ tb/sv/tb_utf8_to_ucs2_decoder_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_utf8_to_ucs2_decoder_top: testbench for the UTF-8 to UCS-2 decoder
// Sends directed strings at the reset capacity, then random strings over a
// series of capacity settings, with bursty input, a patterned output stall
// and long output hold-offs. A side checker predicts and compares the words.
// ============================================================================
module tb_utf8_to_ucs2_decoder_top;

    import utu_pkg::*;

    localparam int RESET_CYCLES   = 8;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_BYTES    = 240;
    localparam int LONG_HOLD      = 200;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum int {RX_OPEN, RX_COIN, RX_THIRD, RX_SPARSE} rx_mode_t;

    logic clk;
    logic rst_n;

    utu_byte_if utf8_ch ();
    utu_unit_if ucs2_ch ();
    utu_cfg_if  cfg_ch ();

    int         mismatch_count;
    int         units_pending;
    int         burst_left = 0;
    int         phase_bytes = 0;
    int         hold_requests = 0;
    int         idle_cycles = 0;
    logic [7:0] str_bytes[$];
    logic [8:0] directed_seq [0:28];

    utf8_to_ucs2_decoder_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .utf8  (utf8_ch),
        .ucs2  (ucs2_ch),
        .cfg   (cfg_ch)
    );

    utu_decode_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (utf8_ch.valid),
        .byte_ready    (utf8_ch.ready),
        .data_byte     (utf8_ch.data_byte),
        .final_byte    (utf8_ch.final_byte),
        .unit_valid    (ucs2_ch.valid),
        .unit_ready    (ucs2_ch.ready),
        .code_unit     (ucs2_ch.code_unit),
        .is_terminator (ucs2_ch.is_terminator),
        .cfg_valid     (cfg_ch.valid),
        .cfg_ready     (cfg_ch.ready),
        .cfg_capacity  (cfg_ch.capacity),
        .fail_count    (mismatch_count),
        .units_pending (units_pending)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // watchdog: too long without any word moving on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (utf8_ch.valid && utf8_ch.ready) || (ucs2_ch.valid && ucs2_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: stall pattern changes every stretch; long hold-off on request
    initial
    begin
        rx_mode_t mode;
        int       span;
        int       tick;
        int       hold_left;
        int       holds_served;
        logic     take;
        mode         = RX_OPEN;
        span         = 0;
        tick         = 0;
        hold_left    = 0;
        holds_served = 0;
        ucs2_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && holds_served != hold_requests)
            begin
                holds_served++;
                hold_left = LONG_HOLD;
            end
            if (span == 0)
            begin
                mode = rx_mode_t'($urandom_range(0, 3));
                span = $urandom_range(10, 80);
            end
            span--;
            tick++;
            case (mode)
                RX_OPEN:   take = 1'b1;
                RX_COIN:   take = 1'($urandom_range(0, 1));
                RX_THIRD:  take = (tick % 3 == 0);
                default:   take = ($urandom_range(0, 3) == 0);
            endcase
            if (hold_left > 0)
            begin
                hold_left--;
                take = 1'b0;
            end
            ucs2_ch.ready <= take;
        end
    end

    // send one byte word; bursts of random length with random gaps between
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                utf8_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 32);
        end
        utf8_ch.valid      <= 1'b1;
        utf8_ch.data_byte  <= b;
        utf8_ch.final_byte <= last;
        do
            @(posedge clk);
        while (utf8_ch.ready !== 1'b1);
        burst_left--;
        phase_bytes++;
    endtask

    // wait until every predicted word has come out, then let the block settle
    task automatic wait_drained(input int settle);
        utf8_ch.valid <= 1'b0;
        @(posedge clk);
        while (units_pending != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] value);
        cfg_ch.valid    <= 1'b1;
        cfg_ch.capacity <= value;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
    endtask

    // continuation byte; now and then any value, since it is never checked
    function automatic logic [7:0] cont_byte(input logic [5:0] bits);
        return ($urandom_range(0, 7) == 0) ? 8'($urandom) : {2'b10, bits};
    endfunction

    // lead byte for a 2..6 byte sequence with random payload bits
    function automatic logic [7:0] lead_byte(input int len);
        case (len)
            2:       return {3'b110, 5'($urandom)};
            3:       return {4'b1110, 4'($urandom)};
            4:       return {5'b11110, 3'($urandom)};
            5:       return {6'b111110, 2'($urandom)};
            default: return {7'b1111110, 1'($urandom)};
        endcase
    endfunction

    function automatic void push_two(input logic [15:0] v);
        str_bytes.push_back({3'b110, v[10:6]});
        str_bytes.push_back(cont_byte(v[5:0]));
    endfunction

    function automatic void push_three(input logic [15:0] v);
        str_bytes.push_back({4'b1110, v[15:12]});
        str_bytes.push_back(cont_byte(v[11:6]));
        str_bytes.push_back(cont_byte(v[5:0]));
    endfunction

    // lead byte followed by too few continuation bytes
    function automatic void push_partial();
        int len;
        len = $urandom_range(2, 6);
        str_bytes.push_back(lead_byte(len));
        repeat ($urandom_range(0, len - 2)) str_bytes.push_back(cont_byte(6'($urandom)));
    endfunction

    // mostly well-formed characters, some overlong, long, invalid or broken
    function automatic void push_random_char();
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            str_bytes.push_back(8'($urandom_range(0, 127)));
        else if (pick < 48)
            push_two(16'($urandom_range(16'h0080, 16'h07FF)));
        else if (pick < 66)
            push_three(16'($urandom_range(16'h0800, 16'hFFFF)));
        else if (pick < 72)
        begin
            if ($urandom_range(0, 1) == 0)
                push_two(16'($urandom_range(0, 16'h007F)));
            else
                push_three(16'($urandom_range(0, 16'h07FF)));
        end
        else if (pick < 80)
        begin
            len = $urandom_range(4, 6);
            str_bytes.push_back(lead_byte(len));
            repeat (len - 1) str_bytes.push_back(cont_byte(6'($urandom)));
        end
        else if (pick < 86)
        begin
            if ($urandom_range(0, 1) == 0)
                str_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
            else
                str_bytes.push_back($urandom_range(0, 1) ? 8'hFE : 8'hFF);
        end
        else if (pick < 93)
            push_partial();
        else
            str_bytes.push_back(8'($urandom));
    endfunction

    // one string, sometimes long, sometimes cut inside its last sequence
    task automatic send_random_string();
        int chars;
        chars = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 10);
        repeat (chars) push_random_char();
        if ($urandom_range(0, 5) == 0)
            push_partial();
        foreach (str_bytes[i])
            send_byte(str_bytes[i], i == str_bytes.size() - 1);
        str_bytes.delete();
    endtask

    // stimulus and verdict
    initial
    begin
        logic [15:0] cap_plan [0:NUM_PHASES-1];
        rst_n              <= 1'b0;
        utf8_ch.valid      <= 1'b0;
        utf8_ch.data_byte  <= 8'h00;
        utf8_ch.final_byte <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.capacity    <= 16'h0000;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed strings at reset capacity; bit 8 marks the final byte
        directed_seq = '{
            // ASCII, zero byte, smallest 2-byte, overlong 2-byte at string end
            9'h041, 9'h000, 9'h07F, 9'h0C2, 9'h080, 9'h0C1, 9'h1BF,
            // smallest, overlong, surrogate and largest 3-byte forms
            9'h0E0, 9'h0A0, 9'h080, 9'h0E0, 9'h09F, 9'h0BF,
            9'h0ED, 9'h0A0, 9'h080, 9'h0EF, 9'h0BF, 9'h1BF,
            // 4-byte form, invalid leads, 6-byte form cut by string end
            9'h0F0, 9'h090, 9'h080, 9'h080, 9'h0FE, 9'h0FF, 9'h080,
            9'h0FC, 9'h180,
            // lone 5-byte lead as the final byte
            9'h1F8
        };
        foreach (directed_seq[i])
            send_byte(directed_seq[i][7:0], directed_seq[i][8]);

        // capacity settings: tiny buffers, zero, both ends of the range
        cap_plan = '{16'd3, 16'd1, 16'd0, 16'd2, 16'hFFFF, 16'd5, 16'hFFFE, 16'd0};
        cap_plan[NUM_PHASES-1] = 16'($urandom_range(4, 64));

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_drained(SETTLE_CYCLES);
            write_capacity(cap_plan[phase]);
            // long output hold-off while bytes keep coming
            if (phase == 4 || phase == 6)
                hold_requests++;
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
                send_random_string();
        end

        wait_drained(DRAIN_CYCLES);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
